[hdl/assert_macros.svh]
// assertion helpers shared by the utq modules
// both expect clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define UTQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be true outside reset
`define UTQ_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[hdl/utq_pkg.sv]
// ----------------------------------------------------------------------------
// utq_pkg
// Types and constants of the console transmit queue with newline expansion.
// ----------------------------------------------------------------------------
package utq_pkg;

    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic       FUNC_WRITE = 1'b0;
    localparam logic       FUNC_TICK  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       end_of_write;
    } utq_in_t;

    typedef struct packed {
        logic [1:0]  accepted_count;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_armed;
        logic [31:0] drop_count;
        logic [10:0] fill_level;
    } utq_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic push_cr;
        logic push_lf;
        logic push_byte;
        logic read;
        logic finish;
    } utq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_write;
        logic expand;
        logic tick_go;
    } utq_status_t;

endpackage

[hdl/utq_ram.sv]
// ----------------------------------------------------------------------------
// utq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module utq_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/utq_datapath.sv]
// ----------------------------------------------------------------------------
// utq_datapath
// Ring pointers, drop tracking, interrupt enable and result assembly.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utq_datapath import utq_pkg::*; #(
    parameter int RING_DEPTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  utq_in_t     item,
    input  utq_cmd_t    cmd,
    output utq_status_t st,
    output utq_out_t    result
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int LW = PW + 1;
    localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);
    localparam logic [LW-1:0] DEPTH_L   = LW'(RING_DEPTH);

    utq_in_t       item_reg;
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [7:0]    prev_reg;
    logic          seg_drop_reg;
    logic          pair_drop_reg;
    logic          irq_reg;
    logic [31:0]   drops_reg;
    logic [1:0]    acc_reg;
    logic          txv_reg;

    logic [PW-1:0] wptr_inc;
    logic [PW-1:0] rptr_inc;
    logic          push_any;
    logic          sel_drop;
    logic          full;
    logic          do_write;
    logic          hit_full;
    logic          drop_next;
    logic [7:0]    wbyte;
    logic          nonempty;
    logic          irq_fin;
    logic [LW-1:0] diff;
    logic [LW-1:0] lvl;
    logic [LW+10:0] lvl_ext;
    logic [7:0]    ram_rdata;

    assign wptr_inc = (wptr_reg == LAST_SLOT) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc = (rptr_reg == LAST_SLOT) ? '0 : rptr_reg + 1'b1;
    assign nonempty = (wptr_reg != rptr_reg);

    assign push_any = cmd.push_cr | cmd.push_lf | cmd.push_byte;
    // the pair always starts with a fresh drop state
    assign sel_drop = cmd.push_cr ? 1'b0 : (cmd.push_lf ? pair_drop_reg : seg_drop_reg);
    assign full      = (wptr_inc == rptr_reg);
    assign do_write  = push_any && !sel_drop && !full;
    assign hit_full  = push_any && !sel_drop && full;
    assign drop_next = sel_drop | full;
    assign wbyte     = cmd.push_cr ? CH_CR : (cmd.push_lf ? CH_LF : item_reg.data_byte);

    assign irq_fin = (item_reg.func == FUNC_WRITE) ? (irq_reg | nonempty)
                                                   : (irq_reg & nonempty);

    assign st.is_write = (item_reg.func == FUNC_WRITE);
    assign st.expand   = (item_reg.data_byte == CH_LF) && (prev_reg != CH_CR);
    assign st.tick_go  = irq_reg && nonempty;

    utq_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (do_write),
        .re    (cmd.read),
        .addr  (cmd.read ? rptr_reg : wptr_reg),
        .wdata (wbyte),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            prev_reg      <= '0;
            seg_drop_reg  <= 1'b0;
            pair_drop_reg <= 1'b0;
            irq_reg       <= 1'b0;
            drops_reg     <= '0;
            acc_reg       <= '0;
            txv_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                acc_reg <= '0;
                txv_reg <= 1'b0;
            end
            if (do_write)
            begin
                wptr_reg <= wptr_inc;
                acc_reg  <= acc_reg + 1'b1;
            end
            if (hit_full)
            begin
                drops_reg <= drops_reg + 1'b1;
            end
            if (cmd.push_cr || cmd.push_lf)
            begin
                pair_drop_reg <= drop_next;
            end
            if (cmd.push_byte)
            begin
                seg_drop_reg <= drop_next;
            end
            // the run after an expanded pair starts fresh
            if (cmd.push_lf)
            begin
                seg_drop_reg <= 1'b0;
            end
            if (cmd.read)
            begin
                rptr_reg <= rptr_inc;
                txv_reg  <= 1'b1;
            end
            if (cmd.finish)
            begin
                irq_reg <= irq_fin;
                if (item_reg.func == FUNC_WRITE)
                begin
                    prev_reg <= item_reg.data_byte;
                    if (item_reg.end_of_write)
                    begin
                        seg_drop_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // fill level modulo ring depth
    assign diff    = {1'b0, wptr_reg} - {1'b0, rptr_reg};
    assign lvl     = (wptr_reg >= rptr_reg) ? diff : diff + DEPTH_L;
    assign lvl_ext = {{11{1'b0}}, lvl};

    assign result.accepted_count = acc_reg;
    assign result.tx_valid       = txv_reg;
    assign result.tx_byte        = txv_reg ? ram_rdata : 8'h00;
    assign result.irq_armed      = irq_fin;
    assign result.drop_count     = drops_reg;
    assign result.fill_level     = lvl_ext[10:0];

    `UTQ_ASSERT(a_write_leaves_data, do_write |=> (wptr_reg != rptr_reg), "write left ring empty")
    `UTQ_ASSERT(a_read_advances, cmd.read |=> (rptr_reg != $past(rptr_reg)), "read did not advance")
    `UTQ_NEVER(a_acc_range, acc_reg == 2'd3, "more than two bytes accepted")

endmodule

[hdl/utq_ctrl.sv]
// ----------------------------------------------------------------------------
// utq_ctrl
// Sequencer: latches an item, issues pushes or a ring read, strobes the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utq_ctrl import utq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  utq_status_t st,
    output logic        busy,
    output logic        done,
    output utq_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_EXEC    = 4'b0010,
        S_PUSH_LF = 4'b0100,
        S_DONE    = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (st.is_write)
                begin
                    if (st.expand)
                    begin
                        cmd.push_cr = 1'b1;
                        state_next  = S_PUSH_LF;
                    end
                    else
                    begin
                        cmd.push_byte = 1'b1;
                        state_next    = S_DONE;
                    end
                end
                else
                begin
                    cmd.read   = st.tick_go;
                    state_next = S_DONE;
                end
            end
            S_PUSH_LF:
            begin
                cmd.push_lf = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `UTQ_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
    `UTQ_ASSERT(a_start_busy, (start && !busy) |=> busy, "transfer taken without going busy")

endmodule

[hdl/uart_tx_queue_with_crlf_expansion.sv]
// ----------------------------------------------------------------------------
// uart_tx_queue_with_crlf_expansion
// Console UART transmit queue with LF to CR LF expansion and drop counting.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive item and raise start; the transfer happens at the edge where
//   start is high and busy is low. item.func selects a software byte write or
//   a transmitter-empty tick.
//   Output: one result per item, shown on result for a single cycle with done
//   high; the receiver has no way to stall it and must take it then.
// Sequencing
//   A plain write or a tick runs the execute state, then the done state;
//   a line feed that expands to CR LF adds a state that pushes the LF, as
//   the single-port ring takes one byte per cycle. busy drops after done,
//   so items never overlap. A tick that sends reads the ring in the execute
//   cycle and presents the registered read data with done.
// Reset
//   rst_n clears pointers, drop counter, interrupt enable and the sequencer;
//   ring contents stay undefined and are only read after being written.
// ----------------------------------------------------------------------------
module uart_tx_queue_with_crlf_expansion import utq_pkg::*; #(
    parameter int RING_DEPTH = 2048
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  utq_in_t  item,
    output logic     busy,
    output logic     done,
    output utq_out_t result
);

    utq_cmd_t    cmd;
    utq_status_t st;

    utq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    utq_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .st     (st),
        .result (result)
    );

endmodule

[test/uart_tx_queue_with_crlf_expansion_tb.sv]
// ----------------------------------------------------------------------------
// uart_tx_queue_with_crlf_expansion_tb
// Drives byte writes and transmit-empty ticks into the console transmit queue
// and compares every status report with a typed row of a short table of
// fixed items, which come first, or else with a cycle-free model of the
// ring, line feed expansion and per-segment drop logic. Random traffic
// follows: near empty, a fill to near the top, then traffic at the full mark.
// ----------------------------------------------------------------------------
module uart_tx_queue_with_crlf_expansion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utq_pkg::*;

    localparam int unsigned RING_DEPTH = 2048;

    typedef struct packed {
        bit       typed;
        utq_in_t  stim;
        utq_out_t want;
    } table_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    utq_in_t  item;
    logic     busy;
    logic     done;
    utq_out_t result;

    // model of the queue
    logic [7:0]  ring_copy [RING_DEPTH];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    logic [7:0]  prev_written;
    bit          run_dropping;
    bit          irq_enable;
    logic [31:0] segments_dropped;

    utq_out_t    awaited_reports [$];
    utq_out_t    head_report;
    int unsigned mismatches;
    int unsigned call_left;
    bit          calm;
    table_row_t  directed_rows [22];

    uart_tx_queue_with_crlf_expansion #(
        .RING_DEPTH(RING_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .done  (done),
        .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned after_slot(int unsigned p);
        return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int unsigned ring_fill();
        return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
    endfunction

    task automatic enqueue_byte(input logic [7:0] b, inout bit dropping,
                                inout logic [1:0] count);
        int unsigned nx;
        if (!dropping)
        begin
            nx = after_slot(wr_ptr);
            if (nx == rd_ptr)
            begin
                // one drop per segment, the rest of it is discarded
                segments_dropped = segments_dropped + 32'd1;
                dropping = 1'b1;
            end
            else
            begin
                ring_copy[wr_ptr] = b;
                wr_ptr = nx;
                count = count + 2'd1;
            end
        end
    endtask

    task automatic console_queue_step(input utq_in_t it, output utq_out_t rep);
        bit         pair_dropping;
        logic [1:0] n;
        rep = '0;
        n = 2'd0;
        if (it.func == FUNC_WRITE)
        begin
            if (it.data_byte == CH_LF && prev_written != CH_CR)
            begin
                // the cr lf pair is a segment of its own with a fresh drop state
                pair_dropping = 1'b0;
                enqueue_byte(CH_CR, pair_dropping, n);
                enqueue_byte(CH_LF, pair_dropping, n);
                run_dropping = 1'b0;
            end
            else
            begin
                enqueue_byte(it.data_byte, run_dropping, n);
            end
            prev_written = it.data_byte;
            if (it.end_of_write)
                run_dropping = 1'b0;
            if (wr_ptr != rd_ptr)
                irq_enable = 1'b1;
        end
        else if (irq_enable)
        begin
            if (wr_ptr != rd_ptr)
            begin
                rep.tx_valid = 1'b1;
                rep.tx_byte = ring_copy[rd_ptr];
                rd_ptr = after_slot(rd_ptr);
            end
            if (wr_ptr == rd_ptr)
                irq_enable = 1'b0;
        end
        rep.accepted_count = n;
        rep.irq_armed = irq_enable;
        rep.drop_count = segments_dropped;
        rep.fill_level = 11'(ring_fill());
    endtask

    function automatic utq_in_t draw_item(int unsigned tick_pct, int unsigned lf_pct);
        utq_in_t     it;
        int unsigned pick;
        it.func = ($urandom_range(0, 99) < tick_pct) ? FUNC_TICK : FUNC_WRITE;
        pick = $urandom_range(0, 99);
        if (pick < lf_pct)
            it.data_byte = CH_LF;
        else if (pick < lf_pct + 10)
            it.data_byte = CH_CR;
        else
            it.data_byte = 8'($urandom_range(0, 255));
        it.end_of_write = 1'($urandom_range(0, 1));
        if (it.func == FUNC_WRITE)
        begin
            if (call_left == 0)
                call_left = $urandom_range(1, 10);
            call_left--;
            // mostly whole write calls, now and then a stray end flag
            if ($urandom_range(0, 9) != 0)
                it.end_of_write = (call_left == 0);
        end
        return it;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input utq_in_t it, input bit typed, input utq_out_t want);
        int unsigned gap;
        utq_out_t    rep;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        console_queue_step(it, rep);
        awaited_reports.push_back(typed ? want : rep);
        @(negedge clk);
    endtask

    task automatic random_items(int unsigned count, int unsigned tick_pct,
                                int unsigned lf_pct, bit to_full);
        int unsigned k;
        k = 0;
        while (to_full ? (ring_fill() < RING_DEPTH - 8) : (k < count))
        begin
            if (k % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_item(draw_item(tick_pct, lf_pct), 1'b0, '0);
            k++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("report with no item pending");
                mismatches++;
            end
            else
            begin
                head_report = awaited_reports.pop_front();
                check_field("accepted_count", 32'(head_report.accepted_count),
                            32'(result.accepted_count));
                check_field("tx_valid", 32'(head_report.tx_valid), 32'(result.tx_valid));
                check_field("tx_byte", 32'(head_report.tx_byte), 32'(result.tx_byte));
                check_field("irq_armed", 32'(head_report.irq_armed), 32'(result.irq_armed));
                check_field("drop_count", head_report.drop_count, result.drop_count);
                check_field("fill_level", 32'(head_report.fill_level),
                            32'(result.fill_level));
            end
        end
    end

    initial
    begin
        int unsigned guard;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        calm = 1'b0;
        call_left = 0;
        mismatches = 0;
        wr_ptr = 0;
        rd_ptr = 0;
        prev_written = 8'h00;
        run_dropping = 1'b0;
        irq_enable = 1'b0;
        segments_dropped = 32'd0;

        directed_rows = '{
            // tick while disarmed
            '{1'b1, '{FUNC_TICK,  8'h00, 1'b0}, '{2'd0, 1'b0, 8'h00, 1'b0, 32'd0, 11'd0}},
            '{1'b1, '{FUNC_WRITE, 8'h41, 1'b0}, '{2'd1, 1'b0, 8'h00, 1'b1, 32'd0, 11'd1}},
            // bare line feed expands
            '{1'b1, '{FUNC_WRITE, CH_LF, 1'b0}, '{2'd2, 1'b0, 8'h00, 1'b1, 32'd0, 11'd3}},
            '{1'b1, '{FUNC_WRITE, CH_CR, 1'b0}, '{2'd1, 1'b0, 8'h00, 1'b1, 32'd0, 11'd4}},
            // line feed after carriage return stays single
            '{1'b1, '{FUNC_WRITE, CH_LF, 1'b1}, '{2'd1, 1'b0, 8'h00, 1'b1, 32'd0, 11'd5}},
            '{1'b1, '{FUNC_TICK,  8'h00, 1'b0}, '{2'd0, 1'b1, 8'h41, 1'b1, 32'd0, 11'd4}},
            '{1'b1, '{FUNC_TICK,  8'h00, 1'b0}, '{2'd0, 1'b1, CH_CR, 1'b1, 32'd0, 11'd3}},
            '{1'b1, '{FUNC_TICK,  8'h00, 1'b0}, '{2'd0, 1'b1, CH_LF, 1'b1, 32'd0, 11'd2}},
            '{1'b1, '{FUNC_TICK,  8'h00, 1'b0}, '{2'd0, 1'b1, CH_CR, 1'b1, 32'd0, 11'd1}},
            // last byte out disarms
            '{1'b1, '{FUNC_TICK,  8'h00, 1'b0}, '{2'd0, 1'b1, CH_LF, 1'b0, 32'd0, 11'd0}},
            '{1'b1, '{FUNC_TICK,  8'hFF, 1'b1}, '{2'd0, 1'b0, 8'h00, 1'b0, 32'd0, 11'd0}},
            '{1'b1, '{FUNC_WRITE, 8'h00, 1'b1}, '{2'd1, 1'b0, 8'h00, 1'b1, 32'd0, 11'd1}},
            '{1'b1, '{FUNC_WRITE, 8'hFF, 1'b1}, '{2'd1, 1'b0, 8'h00, 1'b1, 32'd0, 11'd2}},
            '{1'b1, '{FUNC_WRITE, CH_LF, 1'b1}, '{2'd2, 1'b0, 8'h00, 1'b1, 32'd0, 11'd4}},
            // carriage return seen across a call boundary
            '{1'b0, '{FUNC_WRITE, CH_CR, 1'b1}, '0},
            '{1'b0, '{FUNC_WRITE, CH_LF, 1'b0}, '0},
            '{1'b0, '{FUNC_WRITE, CH_LF, 1'b0}, '0},
            '{1'b0, '{FUNC_WRITE, 8'h80, 1'b0}, '0},
            '{1'b0, '{FUNC_WRITE, 8'h7F, 1'b1}, '0},
            '{1'b0, '{FUNC_TICK,  8'h00, 1'b0}, '0},
            '{1'b0, '{FUNC_TICK,  8'hAA, 1'b1}, '0},
            '{1'b0, '{FUNC_TICK,  8'h55, 1'b0}, '0}
        };

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        // near empty, arm and disarm often
        random_items(40, 50, 15, 1'b0);
        // no ticks until the ring is close to full
        random_items(0, 0, 100, 1'b1);
        // hover at the full mark so segments get cut short
        random_items(60, 40, 40, 1'b0);

        start <= 1'b0;
        guard = 0;
        while (awaited_reports.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        if (awaited_reports.size() != 0)
        begin
            $error("%0d reports never arrived", awaited_reports.size());
            mismatches++;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/utq_pkg.sv
hdl/utq_ram.sv
hdl/utq_datapath.sv
hdl/utq_ctrl.sv
hdl/uart_tx_queue_with_crlf_expansion.sv
test/uart_tx_queue_with_crlf_expansion_tb.sv
